FILE: hdl/alcd_pkg.sv
// Package: shared types, constants and the step adaptation table for the ADPCM channel decoder.
`default_nettype none
package alcd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned SCALE_W  = 10;

    localparam logic [STEP_W-1:0] STEP_INIT = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MIN  = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX  = 15'd24576;

    localparam logic signed [SAMPLE_W-1:0] HIST_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] HIST_MAX = 16'sh7FFF;

    localparam logic [POS_W-1:0] POS_STEP = 17'd2;

    typedef enum logic [1:0] {
        CFG_LOOP_START  = 2'd0,
        CFG_LOOP_END    = 2'd1,
        CFG_LOOP_ENABLE = 2'd2,
        CFG_STREAM_MODE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_ADD0,
        ST_MUL1,
        ST_ADD1,
        ST_ENDP,
        ST_OUT0,
        ST_OUT1
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic nib_hi;
        logic endp;
    } t_cmd;

    typedef struct packed {
        logic run;
    } t_sts;

    function automatic logic [SCALE_W-1:0] scale_lut(input logic [2:0] mag);
        logic [SCALE_W-1:0] res;
        begin
            case (mag)
                3'd4:    res = 10'd307;
                3'd5:    res = 10'd409;
                3'd6:    res = 10'd512;
                3'd7:    res = 10'd614;
                default: res = 10'd230;
            endcase
            return res;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hdl/alcd_in_if.sv
// Interface: input channel carrying one code byte and the restart flag per beat.
`default_nettype none
interface alcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       restart;

    modport source (output valid, output code_byte, output restart, input ready);
    modport sink   (input valid, input code_byte, input restart, output ready);
endinterface
`default_nettype wire

FILE: hdl/alcd_out_if.sv
// Interface: output channel carrying one decoded sample and channel status per beat.
`default_nettype none
interface alcd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               pair_last;
    logic               loop_hit;
    logic               still_running;
    logic [16:0]        next_pos;

    modport source (output valid, output sample, output pair_last, output loop_hit,
                    output still_running, output next_pos, input ready);
    modport sink   (input valid, input sample, input pair_last, input loop_hit,
                    input still_running, input next_pos, output ready);
endinterface
`default_nettype wire

FILE: hdl/alcd_dp.sv
// Datapath: history and step update, loop position logic, config registers and sample buffers.
`default_nettype none
module alcd_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire alcd_pkg::t_cmd         i_cmd,
    output alcd_pkg::t_sts              o_sts,
    input  wire logic                   i_cfg_we,
    input  wire alcd_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [15:0]            i_cfg_data,
    input  wire logic [7:0]             i_code_byte,
    input  wire logic                   i_restart,
    input  wire logic                   i_out_sel,
    output logic signed [15:0]          o_sample,
    output logic                        o_loop_hit,
    output logic                        o_still_running,
    output logic [16:0]                 o_next_pos
);
    import alcd_pkg::*;

    logic [CFG_W-1:0]           r_loop_start;
    logic [CFG_W-1:0]           r_loop_end;
    logic                       r_loop_en;
    logic                       r_stream;

    logic signed [SAMPLE_W-1:0] r_hist;
    logic [STEP_W-1:0]          r_step;
    logic [POS_W-1:0]           r_pos;
    logic                       r_active;
    logic                       r_looped;

    logic [BYTE_W-1:0]          r_byte;
    logic signed [SAMPLE_W-1:0] r_hsc;
    logic [15:0]                r_diff;
    logic [24:0]                r_sprod;
    logic signed [SAMPLE_W-1:0] r_s0;
    logic signed [SAMPLE_W-1:0] r_s1;

    logic [3:0]                 w_nib;
    logic signed [23:0]         w_hext;
    logic signed [23:0]         w_hprod;
    logic signed [23:0]         w_hadj;
    logic [18:0]                w_dprod;
    logic [24:0]                w_sprod;
    logic signed [17:0]         w_sum;
    logic signed [SAMPLE_W-1:0] w_hnew;
    logic [16:0]                w_sraw;
    logic [STEP_W-1:0]          w_snew;
    logic [POS_W-1:0]           w_end_ext;

    assign o_sts.run = i_restart | r_active;

    assign w_nib     = i_cmd.nib_hi ? r_byte[7:4] : r_byte[3:0];
    assign w_hext    = 24'(r_hist);
    assign w_hprod   = (w_hext <<< 8) - (w_hext <<< 1);
    assign w_hadj    = w_hprod[23] ? (w_hprod + 24'sd255) : w_hprod;
    assign w_dprod   = 19'({w_nib[2:0], 1'b1}) * 19'(r_step);
    assign w_sprod   = 25'(scale_lut(w_nib[2:0])) * 25'(r_step);
    assign w_end_ext = {1'b0, r_loop_end};

    always_comb begin
        if (w_nib[3]) begin
            w_sum = 18'(r_hsc) - $signed({2'b00, r_diff});
        end else begin
            w_sum = 18'(r_hsc) + $signed({2'b00, r_diff});
        end
        if (w_sum < 18'(HIST_MIN)) begin
            w_hnew = HIST_MIN;
        end else if (w_sum > 18'(HIST_MAX)) begin
            w_hnew = HIST_MAX;
        end else begin
            w_hnew = w_sum[15:0];
        end
        w_sraw = r_sprod[24:8];
        if (w_sraw < 17'(STEP_MIN)) begin
            w_snew = STEP_MIN;
        end else if (w_sraw > 17'(STEP_MAX)) begin
            w_snew = STEP_MAX;
        end else begin
            w_snew = w_sraw[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_start <= '0;
            r_loop_end   <= '0;
            r_loop_en    <= 1'b0;
            r_stream     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOOP_START:  r_loop_start <= i_cfg_data;
                CFG_LOOP_END:    r_loop_end   <= i_cfg_data;
                CFG_LOOP_ENABLE: r_loop_en    <= i_cfg_data[0];
                CFG_STREAM_MODE: r_stream     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_step   <= STEP_INIT;
            r_pos    <= '0;
            r_active <= 1'b0;
            r_looped <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_restart) begin
                r_hist   <= '0;
                r_step   <= STEP_INIT;
                r_pos    <= '0;
                r_active <= 1'b1;
                r_looped <= 1'b0;
            end
        end else if (i_cmd.add) begin
            r_hist <= w_hnew;
            r_step <= w_snew;
        end else if (i_cmd.endp) begin
            if (r_pos >= w_end_ext) begin
                r_looped <= 1'b1;
                if (r_loop_en) begin
                    r_pos <= 17'(r_loop_start) + POS_STEP;
                    if (!r_stream) begin
                        r_step <= STEP_INIT;
                        r_hist <= '0;
                    end
                end else begin
                    r_pos    <= w_end_ext;
                    r_active <= 1'b0;
                end
            end else begin
                r_pos <= r_pos + POS_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_code_byte;
        end
        if (i_cmd.mul) begin
            r_hsc   <= w_hadj[23:8];
            r_diff  <= w_dprod[18:3];
            r_sprod <= w_sprod;
        end
        if (i_cmd.add) begin
            if (i_cmd.nib_hi) begin
                r_s1 <= w_hnew;
            end else begin
                r_s0 <= w_hnew;
            end
        end
    end

    assign o_sample        = i_out_sel ? r_s1 : r_s0;
    assign o_loop_hit      = r_looped;
    assign o_still_running = r_active;
    assign o_next_pos      = r_pos;

endmodule
`default_nettype wire

FILE: hdl/alcd_ctrl.sv
// Controller: sequences the two nibble updates, the end-of-pair step and the two output beats.
`default_nettype none
module alcd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_out_sel,
    output alcd_pkg::t_cmd      o_cmd,
    input  wire alcd_pkg::t_sts i_sts
);
    import alcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.run) begin
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: n_state = ST_ADD0;
            ST_ADD0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_ADD1;
            ST_ADD1: n_state = ST_ENDP;
            ST_ENDP: n_state = ST_OUT0;
            ST_OUT0: begin
                if (i_out_ready) begin
                    n_state = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_out_sel     = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL0: o_cmd.mul = 1'b1;
            ST_ADD0: o_cmd.add = 1'b1;
            ST_MUL1: begin
                o_cmd.mul    = 1'b1;
                o_cmd.nib_hi = 1'b1;
            end
            ST_ADD1: begin
                o_cmd.add    = 1'b1;
                o_cmd.nib_hi = 1'b1;
            end
            ST_ENDP: o_cmd.endp = 1'b1;
            ST_OUT0: o_out_valid = 1'b1;
            ST_OUT1: begin
                o_out_valid = 1'b1;
                o_out_sel   = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/adpcm_loop_channel_decoder.sv
// Top level: 4-bit ADPCM channel decoder with loop handling.
// Each accepted beat carries one code byte; while the channel runs it yields two sample beats,
// low nibble first, both carrying the loop flag, run status and position after the byte. A beat
// with restart set restarts the channel and is then decoded. While stopped, beats are taken and
// dropped. A byte is taken in the idle state, then passes a multiply and an add step per nibble
// in the shared multiply/accumulate datapath, the loop check and the two output beats; the
// input is held off until both sample beats are taken. No clearing pass follows reset.
`default_nettype none
module adpcm_loop_channel_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    alcd_in_if.sink                 i_in,
    alcd_out_if.source              o_out,
    input  wire logic               i_cfg_we,
    input  wire alcd_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);
    import alcd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_out_sel;

    alcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_sel   (w_out_sel),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    alcd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_code_byte     (i_in.code_byte),
        .i_restart       (i_in.restart),
        .i_out_sel       (w_out_sel),
        .o_sample        (o_out.sample),
        .o_loop_hit      (o_out.loop_hit),
        .o_still_running (o_out.still_running),
        .o_next_pos      (o_out.next_pos)
    );

    assign o_out.pair_last = w_out_sel;

endmodule
`default_nettype wire

FILE: hdl/alcd_chk.sv
// Checker: port-level properties of the decoder, bound to the top level.
`default_nettype none
module alcd_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_sample,
    input wire logic        i_pair_last,
    input wire logic [16:0] i_next_pos,
    input wire logic        i_loop_hit
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sample)))
        else $error("stalled output beat changed");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_pair_last) |=> (i_out_valid && i_pair_last))
        else $error("second sample of pair did not follow the first");

    a_pair_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_pair_last)
            |=> ($stable(i_next_pos) && $stable(i_loop_hit)))
        else $error("status differs between samples of a pair");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result is pending");

endmodule

bind adpcm_loop_channel_decoder alcd_chk u_alcd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sample    (o_out.sample),
    .i_pair_last (o_out.pair_last),
    .i_next_pos  (o_out.next_pos),
    .i_loop_hit  (o_out.loop_hit)
);
`default_nettype wire
